// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types, constants and helpers of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    // field widths
    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int ADDR_W  = 11;
    localparam int CELL_W  = CHAR_W + ATTR_W;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;

    // stream widths
    localparam int IN_DATA_BITS  = CHAR_W + ADDR_W;
    localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = CELL_W + ROW_W + COL_W;
    localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR     = 8'h0a;
    localparam logic [CHAR_W-1:0] BLANK_CHAR       = 8'h20;
    localparam logic [ATTR_W-1:0] TEXT_COLOR_RESET = 8'h07;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // one cycle of screen memory traffic
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // payload of one result
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CELL_W-1:0] entry;
    } res_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

// ===== sv/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_top
// character-cell console engine with an 80x25 screen store and a cursor
// ----------------------------------------------------------------------------
// Each input transfer is one command (put character, erase backwards, clear
// screen, read cell) and gives exactly one output transfer carrying the cell
// read (zero for other commands) and the cursor after the command. A put or
// erase finishes when accepted; a read waits for the screen memory's
// registered read data. A newline or a put in the last column of the last
// row scrolls: rows 1 to 24 are copied up one row through the single
// memory port pair and the bottom row is blanked. A clear sweeps all 2000
// cells, one write a cycle. After reset a like clearing pass, filling with
// the reset attribute, runs before the first input transfer is taken;
// text_color writes are taken at any time. The result sits in a holding
// register and then an output register, so a new command is accepted while
// a finished result still waits on the master side.
// ----------------------------------------------------------------------------
module text_console_writer_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: text_color attribute
    input  logic                            cfg_wen,
    input  logic [tcw_pkg::ATTR_W-1:0]      cfg_wdata,
    // command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tcw_pkg::IN_DATA_W-1:0]   s_tdata,   // ch[7:0], cell_index[18:8]
    input  logic [tcw_pkg::CMD_W-1:0]       s_tuser,   // cmd[1:0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcw_pkg::OUT_DATA_W-1:0]  m_tdata    // cell_entry[15:0],
                                                       // cursor_row[20:16],
                                                       // cursor_col[27:21]
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] text_color_reg;
    logic              out_valid_reg;
    res_t              out_data_reg;

    mem_req_t          mem_req;
    logic [CELL_W-1:0] rdata;
    logic              res_valid;
    res_t              res;
    logic              res_take;

    // attribute register, reset to light grey on black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= TEXT_COLOR_RESET;
        end
        else if (cfg_wen)
        begin
            text_color_reg <= cfg_wdata;
        end
    end

    // screen store
    tcw_screen_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // command sequencer
    tcw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .cmd        (s_tuser),
        .ch         (s_tdata[CHAR_W-1:0]),
        .cell_index (s_tdata[CHAR_W+ADDR_W-1:CHAR_W]),
        .text_color (text_color_reg),
        .mem_req    (mem_req),
        .rdata      (rdata),
        .res_take   (res_take),
        .res_valid  (res_valid),
        .res        (res)
    );

    // output register: takes the held result when empty or being drained
    assign res_take = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_DATA_BITS){1'b0}}, out_data_reg};

`ifndef SYNTHESIS
    // the sequencer never addresses a cell beyond the screen
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (mem_req.waddr < ADDR_W'(CELLS)))
        else $error("screen write outside store");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.re |-> (mem_req.raddr < ADDR_W'(CELLS)))
        else $error("screen read outside store");

    // a held result is kept intact until the output register takes it
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_take) |=> (res_valid && $stable(res)))
        else $error("held result lost or changed");

    // reported cursor stays on the screen
    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_data_reg.row < ROW_W'(ROWS))
                      && (out_data_reg.col < COL_W'(COLUMNS))))
        else $error("cursor off screen");
`endif

endmodule

// ===== sv/tcw_screen_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_ram
// screen cell store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tcw_screen_ram (
    input  logic               clk,
    input  tcw_pkg::mem_req_t  req,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcw_ctrl
// command sequencer: cursor, screen sweeps and result holding register
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tcw_pkg::CMD_W-1:0]   cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]  ch,
    input  logic [tcw_pkg::ADDR_W-1:0]  cell_index,
    input  logic [tcw_pkg::ATTR_W-1:0]  text_color,
    output tcw_pkg::mem_req_t           mem_req,
    input  logic [tcw_pkg::CELL_W-1:0]  rdata,
    input  logic                        res_take,
    output logic                        res_valid,
    output tcw_pkg::res_t               res
);
    import tcw_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_SCROLL = 5'b00100,
        S_BLANK  = 5'b01000,
        S_CLEAR  = 5'b10000
    } state_t;

    state_t            state_reg,   state_next;
    logic [ROW_W-1:0]  row_reg,     row_next;
    logic [COL_W-1:0]  col_reg,     col_next;
    logic [ADDR_W-1:0] ptr_reg,     ptr_next;
    logic              cp_wr_reg,   cp_wr_next;
    logic [ADDR_W-1:0] cp_dst_reg,  cp_dst_next;
    logic              init_reg,    init_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg,     res_next;

    logic              accept;
    logic              res_load;
    logic [CELL_W-1:0] res_entry;
    logic [CELL_W-1:0] blank;
    logic              wrap_col;
    logic              last_row;
    logic [ROW_W-1:0]  er_row;
    logic [COL_W-1:0]  er_col;

    assign s_tready = (state_reg == S_IDLE) && (!res_valid_reg || res_take);
    assign accept   = s_tvalid && s_tready;

    // the power-up pass fills with the reset attribute
    assign blank    = {(init_reg ? TEXT_COLOR_RESET : text_color), BLANK_CHAR};
    assign wrap_col = (col_reg == COL_W'(COLUMNS - 1));
    assign last_row = (row_reg == ROW_W'(ROWS - 1));

    // cursor after a backspace
    always_comb
    begin
        er_row = row_reg;
        er_col = col_reg;
        if (col_reg != '0)
        begin
            er_col = col_reg - COL_W'(1);
        end
        else if (row_reg != '0)
        begin
            er_row = row_reg - ROW_W'(1);
            er_col = COL_W'(COLUMNS - 1);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        ptr_next    = ptr_reg;
        cp_wr_next  = cp_wr_reg;
        cp_dst_next = cp_dst_reg;
        init_next   = init_reg;
        mem_req     = '0;
        res_load    = 1'b0;
        res_entry   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_PUT:
                        begin
                            if (ch != NEWLINE_CHAR)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = cell_addr(row_reg, col_reg);
                                mem_req.wdata = {text_color, ch};
                            end
                            if ((ch == NEWLINE_CHAR) || wrap_col)
                            begin
                                col_next = '0;
                                if (last_row)
                                begin
                                    state_next = S_SCROLL;
                                    ptr_next   = '0;
                                    cp_wr_next = 1'b0;
                                end
                                else
                                begin
                                    row_next = row_reg + ROW_W'(1);
                                    res_load = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + COL_W'(1);
                                res_load = 1'b1;
                            end
                        end
                        CMD_ERASE:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = cell_addr(er_row, er_col);
                            mem_req.wdata = blank;
                            row_next      = er_row;
                            col_next      = er_col;
                            res_load      = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            ptr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        CMD_READ:
                        begin
                            if (cell_index < ADDR_W'(CELLS))
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = cell_index;
                                state_next    = S_READ;
                            end
                            else
                            begin
                                res_load = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_load   = 1'b1;
                res_entry  = rdata;
                state_next = S_IDLE;
            end
            S_SCROLL:
            begin
                // read runs one row ahead of the write, so no overlap
                mem_req.re    = 1'b1;
                mem_req.raddr = ptr_reg + ADDR_W'(COLUMNS);
                mem_req.we    = cp_wr_reg;
                mem_req.waddr = cp_dst_reg;
                mem_req.wdata = rdata;
                cp_wr_next    = 1'b1;
                cp_dst_next   = ptr_reg;
                if (ptr_reg == ADDR_W'(CELLS - COLUMNS - 1))
                begin
                    ptr_next   = ADDR_W'(CELLS - COLUMNS);
                    state_next = S_BLANK;
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            S_BLANK:
            begin
                mem_req.we = 1'b1;
                if (cp_wr_reg)
                begin
                    // last copied cell still in flight
                    mem_req.waddr = cp_dst_reg;
                    mem_req.wdata = rdata;
                    cp_wr_next    = 1'b0;
                end
                else
                begin
                    mem_req.waddr = ptr_reg;
                    mem_req.wdata = blank;
                    if (ptr_reg == ADDR_W'(CELLS - 1))
                    begin
                        state_next = S_IDLE;
                        res_load   = 1'b1;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + ADDR_W'(1);
                    end
                end
            end
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg;
                mem_req.wdata = blank;
                if (ptr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                    init_next  = 1'b0;
                    res_load   = !init_reg;
                end
                else
                begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_next = res_reg;
        if (res_load)
        begin
            res_next.entry = res_entry;
            res_next.row   = row_next;
            res_next.col   = col_next;
        end
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_take)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            ptr_reg       <= '0;
            cp_wr_reg     <= 1'b0;
            init_reg      <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            ptr_reg       <= ptr_next;
            cp_wr_reg     <= cp_wr_next;
            init_reg      <= init_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_dst_reg <= cp_dst_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
